// ===== design/ph_sensor_trimmed_average_assert.svh =====
`ifndef PH_SENSOR_TRIMMED_AVERAGE_ASSERT_SVH
`define PH_SENSOR_TRIMMED_AVERAGE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PTAV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptav check failed");

// next-cycle implication, checked outside reset
`define PTAV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptav check failed");

`endif

// ===== design/ptav_pkg.sv =====
package ptav_pkg;

	localparam int WINDOW   = 12;
	localparam int SAMPLE_W = 12;
	localparam int IDX_W    = $clog2(WINDOW);
	// at most WINDOW-2 counted entries
	localparam int CNT_W    = $clog2(WINDOW - 1);
	localparam int SUM_W    = $clog2((WINDOW - 2) * ((1 << SAMPLE_W) - 1) + 1);
	localparam int DBIT_W   = $clog2(SUM_W);

	localparam int VOLT_W     = 15;
	localparam int COEF_W     = 24;
	localparam int PH_W       = 32;
	localparam int SQ_W       = 2 * VOLT_W;
	localparam int MUL_A_W    = COEF_W + 1;
	localparam int MUL_B_W    = SQ_W + 1;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int FRAC_SHIFT = 24;
	localparam int LIN_SHIFT  = 12;
	localparam int QW         = ACC_W - FRAC_SHIFT;

	localparam logic signed [COEF_W-1:0] COEF_CONST_RST  = 24'sd65536;
	localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST = 24'sd292534;
	localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST = -24'sd23409;

	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_COEF_CONST,
		REG_COEF_LINEAR,
		REG_COEF_SQUARE
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] c_const;
		logic signed [COEF_W-1:0] c_linear;
		logic signed [COEF_W-1:0] c_square;
	} coef_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_IDLE,
		OP_SEED,
		OP_SCAN,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_VOLT,
		OP_MSQ,
		OP_MLIN,
		OP_MQUAD,
		OP_ACC,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		WT_NONE,
		WT_INPUT,
		WT_OUTPUT
	} wait_t;

	typedef enum logic [1:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_SCAN_MORE,
		JC_DIV_MORE
	} jump_t;

	localparam int PROG_LEN = 11;
	localparam int STEP_W   = $clog2(PROG_LEN);

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t S_IDLE    = STEP_W'(0);
	localparam step_t S_SEED    = STEP_W'(1);
	localparam step_t S_SCAN    = STEP_W'(2);
	localparam step_t S_DIVINIT = STEP_W'(3);
	localparam step_t S_DIV     = STEP_W'(4);
	localparam step_t S_VOLT    = STEP_W'(5);
	localparam step_t S_MSQ     = STEP_W'(6);
	localparam step_t S_MLIN    = STEP_W'(7);
	localparam step_t S_MQUAD   = STEP_W'(8);
	localparam step_t S_ACC     = STEP_W'(9);
	localparam step_t S_OUT     = STEP_W'(10);

	typedef struct packed {
		op_t   op;
		wait_t wt;
		jump_t jc;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		op_t  op;
		logic go;
	} ctl_t;

	typedef struct packed {
		logic in_avail;
		logic out_busy;
		logic scan_more;
		logic div_more;
	} status_t;

	// microcode store
	function automatic ctrl_word_t rom_word(step_t s);
		ctrl_word_t w;
		unique case (s)
			S_IDLE:    w = '{OP_IDLE,    WT_INPUT,  JC_NEVER,     S_IDLE};
			S_SEED:    w = '{OP_SEED,    WT_NONE,   JC_NEVER,     S_IDLE};
			S_SCAN:    w = '{OP_SCAN,    WT_NONE,   JC_SCAN_MORE, S_SCAN};
			S_DIVINIT: w = '{OP_DIVINIT, WT_NONE,   JC_NEVER,     S_IDLE};
			S_DIV:     w = '{OP_DIVSTEP, WT_NONE,   JC_DIV_MORE,  S_DIV};
			S_VOLT:    w = '{OP_VOLT,    WT_NONE,   JC_NEVER,     S_IDLE};
			S_MSQ:     w = '{OP_MSQ,     WT_NONE,   JC_NEVER,     S_IDLE};
			S_MLIN:    w = '{OP_MLIN,    WT_NONE,   JC_NEVER,     S_IDLE};
			S_MQUAD:   w = '{OP_MQUAD,   WT_NONE,   JC_NEVER,     S_IDLE};
			S_ACC:     w = '{OP_ACC,     WT_NONE,   JC_NEVER,     S_IDLE};
			S_OUT:     w = '{OP_OUT,     WT_OUTPUT, JC_ALWAYS,    S_IDLE};
			default:   w = '{OP_NOP,     WT_NONE,   JC_ALWAYS,    S_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== design/ptav_seq.sv =====
`include "ph_sensor_trimmed_average_assert.svh"

module ptav_seq import ptav_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctl_t    ctl
);

	step_t      step_q;
	step_t      step_d;
	ctrl_word_t word;
	logic       stall;
	logic       jump;

	always_comb begin
		word = rom_word(step_q);
	end

	// wait and branch conditions of the current control word
	always_comb begin
		unique case (word.wt)
			WT_INPUT:  stall = !status.in_avail;
			WT_OUTPUT: stall = status.out_busy;
			default:   stall = 1'b0;
		endcase
		unique case (word.jc)
			JC_ALWAYS:    jump = 1'b1;
			JC_SCAN_MORE: jump = status.scan_more;
			JC_DIV_MORE:  jump = status.div_more;
			default:      jump = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		priority if (stall) begin
			step_d = step_q;
		end else if (jump) begin
			step_d = word.target;
		end else begin
			step_d = step_q + 1'b1;
		end
	end

	// outputs
	always_comb begin
		ctl.op = word.op;
		ctl.go = !stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	`PTAV_ASSERT_NOW(a_step_range, clk, arst_n, 1'b1, 32'(step_q) < PROG_LEN)
	`PTAV_ASSERT_NEXT(a_out_to_idle, clk, arst_n, ctl.op == OP_OUT && ctl.go, step_q == S_IDLE)

endmodule

// ===== design/ptav_dp.sv =====
`include "ph_sensor_trimmed_average_assert.svh"

module ptav_dp import ptav_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_t                   ctl,
	input  coef_t                  coef,
	input  logic                   in_valid,
	input  logic [SAMPLE_W-1:0]    sample,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [SAMPLE_W-1:0]    average,
	output logic [VOLT_W-1:0]      volts_q12,
	output logic signed [PH_W-1:0] ph_q16,
	output logic                   ph_saturated,
	output status_t                status
);

	logic [SAMPLE_W-1:0] window_q [WINDOW];
	logic [IDX_W-1:0]    slot_q;
	logic [IDX_W-1:0]    idx_q;
	logic                out_valid_q;

	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    rem_q;
	logic [SUM_W-1:0]    quo_q;
	logic [DBIT_W-1:0]   bit_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [VOLT_W-1:0]   vq_q;
	logic [SQ_W-1:0]     sq_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic [SAMPLE_W-1:0] average_q;
	logic [VOLT_W-1:0]   volts_q;
	logic [PH_W-1:0]     ph_q;
	logic                sat_q;

	logic                do_op;
	logic [SAMPLE_W-1:0] elem;
	logic [SAMPLE_W-1:0] addend;
	logic                take_lo;
	logic                take_hi;
	logic [CNT_W:0]      rem_sh;
	logic                rem_ge;
	logic [SAMPLE_W-1:0] avg_d;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [ACC_W-1:0]   prod_ext;
	logic [QW-1:0]       q_wide;
	logic                sat_d;
	logic [PH_W-1:0]     ph_d;

	assign do_op = ctl.go;

	// one window entry per scan step
	always_comb begin
		elem    = window_q[idx_q];
		take_lo = elem < lo_q;
		take_hi = !take_lo && (elem > hi_q);
		priority if (take_lo) begin
			addend = lo_q;
		end else if (take_hi) begin
			addend = hi_q;
		end else begin
			addend = elem;
		end
	end

	// restoring division, one quotient bit per step
	always_comb begin
		rem_sh = {rem_q, quo_q[SUM_W-1]};
		rem_ge = rem_sh >= {1'b0, cnt_q};
		avg_d  = (cnt_q == '0) ? '0 : quo_q[SAMPLE_W-1:0];
	end

	// shared multiplier operands
	always_comb begin
		unique case (ctl.op)
			OP_MLIN: begin
				mul_a = {coef.c_linear[COEF_W-1], coef.c_linear};
				mul_b = {{(MUL_B_W-VOLT_W){1'b0}}, vq_q};
			end
			OP_MQUAD: begin
				mul_a = {coef.c_square[COEF_W-1], coef.c_square};
				mul_b = {1'b0, sq_q};
			end
			default: begin
				mul_a = {{(MUL_A_W-VOLT_W){1'b0}}, vq_q};
				mul_b = {{(MUL_B_W-VOLT_W){1'b0}}, vq_q};
			end
		endcase
		prod_d   = mul_a * mul_b;
		prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	end

	// floor to Q16 is the arithmetic shift, then clip to 32 bits
	always_comb begin
		q_wide = acc_q[ACC_W-1:FRAC_SHIFT];
		sat_d  = (q_wide[QW-1:PH_W-1] != '0) && (q_wide[QW-1:PH_W-1] != '1);
		if (sat_d) begin
			ph_d = q_wide[QW-1] ? {1'b1, {(PH_W-1){1'b0}}} : {1'b0, {(PH_W-1){1'b1}}};
		end else begin
			ph_d = q_wide[PH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				window_q[i] <= '0;
			end
			slot_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.op == OP_IDLE && do_op) begin
				window_q[slot_q] <= sample;
				slot_q <= (32'(slot_q) == WINDOW - 1) ? '0 : slot_q + 1'b1;
			end
			if (ctl.op == OP_SEED) begin
				idx_q <= IDX_W'(2);
			end else if (ctl.op == OP_SCAN && status.scan_more) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ctl.op == OP_OUT && do_op) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_SEED: begin
				lo_q  <= (window_q[0] < window_q[1]) ? window_q[0] : window_q[1];
				hi_q  <= (window_q[0] < window_q[1]) ? window_q[1] : window_q[0];
				sum_q <= '0;
				cnt_q <= '0;
			end
			OP_SCAN: begin
				// zero entries past the seed pair are skipped
				if (elem != '0) begin
					sum_q <= sum_q + SUM_W'(addend);
					cnt_q <= cnt_q + 1'b1;
					if (take_lo) begin
						lo_q <= elem;
					end
					if (take_hi) begin
						hi_q <= elem;
					end
				end
			end
			OP_DIVINIT: begin
				rem_q <= '0;
				quo_q <= sum_q;
				bit_q <= '0;
			end
			OP_DIVSTEP: begin
				rem_q <= rem_ge ? CNT_W'(rem_sh - {1'b0, cnt_q}) : rem_sh[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], rem_ge};
				bit_q <= bit_q + 1'b1;
			end
			OP_VOLT: begin
				avg_q <= avg_d;
				vq_q  <= VOLT_W'({avg_d, 2'b00}) + VOLT_W'(avg_d);
			end
			OP_MSQ: begin
				prod_q <= prod_d;
			end
			OP_MLIN: begin
				sq_q   <= prod_q[SQ_W-1:0];
				prod_q <= prod_d;
				acc_q  <= {{(ACC_W-FRAC_SHIFT-COEF_W){coef.c_const[COEF_W-1]}},
					coef.c_const, {FRAC_SHIFT{1'b0}}};
			end
			OP_MQUAD: begin
				prod_q <= prod_d;
				acc_q  <= acc_q + (prod_ext <<< LIN_SHIFT);
			end
			OP_ACC: begin
				acc_q <= acc_q + prod_ext;
			end
			OP_OUT: begin
				if (do_op) begin
					average_q <= avg_q;
					volts_q   <= vq_q;
					ph_q      <= ph_d;
					sat_q     <= sat_d;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status.in_avail  = in_valid;
		status.out_busy  = out_valid_q && !out_ready;
		status.scan_more = 32'(idx_q) != WINDOW - 1;
		status.div_more  = 32'(bit_q) != SUM_W - 1;
	end

	assign out_valid    = out_valid_q;
	assign average      = average_q;
	assign volts_q12    = volts_q;
	assign ph_q16       = ph_q;
	assign ph_saturated = sat_q;

	`PTAV_ASSERT_NOW(a_idx_range, clk, arst_n, 1'b1, 32'(idx_q) < WINDOW)
	`PTAV_ASSERT_NOW(a_slot_range, clk, arst_n, 1'b1, 32'(slot_q) < WINDOW)
	`PTAV_ASSERT_NOW(a_lo_le_hi, clk, arst_n, ctl.op == OP_SCAN, lo_q <= hi_q)
	`PTAV_ASSERT_NOW(a_out_from_seq, clk, arst_n, $rose(out_valid_q), $past(ctl.op == OP_OUT))

endmodule

// ===== design/ph_sensor_trimmed_average.sv =====
// pH probe front end: each sample transaction writes one 12-bit reading into a 12-entry window
// (cleared at reset), then the block forms the trimmed mean of the window, scales it to volts
// (average*5, unsigned Q3.12) and applies the quadratic calibration c0 + c1*v + c2*v*v to give
// pH in signed Q16.16, floored and clipped, with a flag when clipping occurred. One sample is
// processed at a time: in_ready returns on the same edge on which out_valid rises, so a new
// sample is accepted only after the previous one has been through the microcoded sequencer's
// scan of the window, one entry per cycle, and its divider, one quotient bit per cycle. The
// result sits in an output register, so the next sample is accepted while it waits to be
// taken; only the output step of that next sample stalls until the previous result is taken.
// Coefficients are written through cfg_we/cfg_idx/cfg_wdata (index 0 constant, 1 linear,
// 2 square; other indexes ignored) and should only be changed while no sample is in flight.
module ph_sensor_trimmed_average import ptav_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_W-1:0]    sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_W-1:0]    average,
	output logic [VOLT_W-1:0]      volts_q12,
	output logic signed [PH_W-1:0] ph_q16,
	output logic                   ph_saturated,
	input  logic                   cfg_we,
	input  logic [REG_IDX_W-1:0]   cfg_idx,
	input  logic [COEF_W-1:0]      cfg_wdata
);

	coef_t   coef_q;
	ctl_t    ctl;
	status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.c_const  <= COEF_CONST_RST;
			coef_q.c_linear <= COEF_LINEAR_RST;
			coef_q.c_square <= COEF_SQUARE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_COEF_CONST:  coef_q.c_const  <= cfg_wdata;
				REG_COEF_LINEAR: coef_q.c_linear <= cfg_wdata;
				REG_COEF_SQUARE: coef_q.c_square <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign in_ready = (ctl.op == OP_IDLE);

	ptav_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	ptav_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.coef         (coef_q),
		.in_valid     (in_valid),
		.sample       (sample),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.average      (average),
		.volts_q12    (volts_q12),
		.ph_q16       (ph_q16),
		.ph_saturated (ph_saturated),
		.status       (status)
	);

endmodule

// ===== bench/tb_ph_sensor_trimmed_average.sv =====
`timescale 1ns / 100ps
module tb_ph_sensor_trimmed_average import ptav_pkg::*;;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 40;
	localparam int PHASE_ITEMS    = 100;
	localparam int DIR_N          = 25;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [COEF_W-1:0] COEF_MAX = 24'h7FFFFF;
	localparam logic [COEF_W-1:0] COEF_MIN = 24'h800000;

	typedef struct {
		logic [SAMPLE_W-1:0]    average;
		logic [VOLT_W-1:0]      volts_q12;
		logic signed [PH_W-1:0] ph_q16;
		logic                   ph_saturated;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [SAMPLE_W-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SAMPLE_W-1:0] average;
	logic [VOLT_W-1:0] volts_q12;
	logic signed [PH_W-1:0] ph_q16;
	logic ph_saturated;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_idx = '0;
	logic [COEF_W-1:0] cfg_wdata = '0;

	// predictor state
	logic [SAMPLE_W-1:0] win_img [WINDOW];
	int win_slot;
	logic signed [COEF_W-1:0] k_const, k_linear, k_square;

	logic [SAMPLE_W-1:0] sample_pending_q [$];
	reading_t reading_expected_q [$];
	int fail_count = 0;
	int tx_gap = 0;
	int rx_stall = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;

	int dir_list [DIR_N] = '{0, 4095, 1, 0, 4095, 4095, 2, 4094, 0, 0, 100, 4000, 5,
		3000, 4095, 0, 1, 4095, 2048, 2047, 1, 4094, 0, 4095, 1};

	ph_sensor_trimmed_average dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average(average),
		.volts_q12(volts_q12),
		.ph_q16(ph_q16),
		.ph_saturated(ph_saturated),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic reading_t calc_reading(logic [SAMPLE_W-1:0] s);
		reading_t r;
		int unsigned lo, hi, sum, cnt, e, avg;
		longint vq, acc, q;
		int i;
		if (win_slot >= WINDOW)
			win_slot = 0;
		win_img[win_slot] = s;
		if (win_img[0] < win_img[1]) begin
			lo = 32'(win_img[0]);
			hi = 32'(win_img[1]);
		end else begin
			lo = 32'(win_img[1]);
			hi = 32'(win_img[0]);
		end
		sum = 0;
		cnt = 0;
		for (i = 2; i < WINDOW; i++) begin
			e = 32'(win_img[i]);
			if (e != 0) begin
				// a new extreme pushes the old one into the sum
				if (e < lo) begin
					sum += lo;
					lo = e;
				end else if (e > hi) begin
					sum += hi;
					hi = e;
				end else begin
					sum += e;
				end
				cnt++;
			end
		end
		avg = (cnt == 0) ? 0 : sum / cnt;
		win_slot = (win_slot + 1) % WINDOW;
		vq = longint'(avg) * 5;
		acc = longint'(k_const) * (longint'(1) <<< 24)
			+ longint'(k_linear) * vq * 4096
			+ longint'(k_square) * vq * vq;
		q = acc >>> 24;
		r.ph_saturated = 1'b0;
		if (q > longint'(32'sh7FFFFFFF)) begin
			q = longint'(32'sh7FFFFFFF);
			r.ph_saturated = 1'b1;
		end else if (q < -longint'(64'sd2147483648)) begin
			q = -longint'(64'sd2147483648);
			r.ph_saturated = 1'b1;
		end
		r.average = avg[SAMPLE_W-1:0];
		r.volts_q12 = vq[VOLT_W-1:0];
		r.ph_q16 = q[PH_W-1:0];
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		else if (r < 92)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// readings clustered around a level, plus zeros, rails and uniform noise
	function automatic logic [SAMPLE_W-1:0] pick_sample(int level);
		int r, v;
		r = $urandom_range(0, 99);
		if (r < 15)
			v = 0;
		else if (r < 25) begin
			case ($urandom_range(0, 3))
				0: v = 0;
				1: v = 1;
				2: v = 4094;
				default: v = 4095;
			endcase
		end else if (r < 60) begin
			v = level + $urandom_range(0, 80) - 40;
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
		end else
			v = $urandom_range(0, 4095);
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: %s: got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic write_coef(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (reg_idx_t'(idx))
			REG_COEF_CONST: k_const = val;
			REG_COEF_LINEAR: k_linear = val;
			REG_COEF_SQUARE: k_square = val;
			default: ;
		endcase
	endtask

	task automatic set_coefs(logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
			logic [COEF_W-1:0] c2);
		write_coef(REG_COEF_CONST, c0);
		write_coef(REG_COEF_LINEAR, c1);
		write_coef(REG_COEF_SQUARE, c2);
	endtask

	// pushes happen on the falling edge, away from the driver's pops
	task automatic queue_random(int n);
		int level, k;
		level = $urandom_range(0, 4095);
		@(negedge clk);
		for (k = 0; k < n; k++)
			sample_pending_q.push_back(pick_sample(level));
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (sample_pending_q.size() != 0 || in_valid || reading_expected_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		bit busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			tx_gap = 0;
		end else begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				reading_expected_q.push_back(calc_reading(sample));
				busy = 1'b0;
			end
			if (!busy) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (sample_pending_q.size() != 0) begin
					in_valid <= 1'b1;
					sample <= sample_pending_q.pop_front();
					if (steady || $urandom_range(0, 9) < 4)
						tx_gap = 0;
					else
						tx_gap = idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (reading_expected_q.size() == 0) begin
					report_mismatch("result with none pending, average",
						longint'(average), longint'(0));
				end else begin
					want = reading_expected_q.pop_front();
					if (average !== want.average)
						report_mismatch("average", longint'(average),
							longint'(want.average));
					if (volts_q12 !== want.volts_q12)
						report_mismatch("volts_q12", longint'(volts_q12),
							longint'(want.volts_q12));
					if (ph_q16 !== want.ph_q16)
						report_mismatch("ph_q16", longint'(ph_q16), longint'(want.ph_q16));
					if (ph_saturated !== want.ph_saturated)
						report_mismatch("ph_saturated", longint'(ph_saturated),
							longint'(want.ph_saturated));
				end
			end
			if (rx_stall > 0)
				rx_stall--;
			else if (!steady && $urandom_range(0, 3) == 0)
				rx_stall = idle_len();
			out_ready <= (rx_stall == 0);
		end
	end

	// watchdog on cycles with no transaction on any port
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("** ph_sensor_trimmed_average: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int p, k;
		for (k = 0; k < WINDOW; k++)
			win_img[k] = '0;
		win_slot = 0;
		k_const = COEF_CONST_RST;
		k_linear = COEF_LINEAR_RST;
		k_square = COEF_SQUARE_RST;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset coefficients, cleared window first
		@(negedge clk);
		for (k = 0; k < DIR_N; k++)
			sample_pending_q.push_back(dir_list[k][SAMPLE_W-1:0]);
		queue_random(PHASE_ITEMS);
		wait_idle();

		for (p = 0; p < 6; p++) begin
			steady = 1'b0;
			case (p)
				0: set_coefs(COEF_MAX, COEF_MAX, COEF_MAX);
				1: set_coefs(COEF_MIN, COEF_MIN, COEF_MIN);
				2: begin
					set_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
					steady = 1'b1;
				end
				3: begin
					set_coefs(COEF_MAX, COEF_MIN, COEF_MAX);
					// ignored index must leave all coefficients alone
					write_coef(REG_UNUSED, COEF_W'($urandom));
				end
				4: set_coefs(COEF_MIN, COEF_MAX, COEF_MIN);
				default: begin
					set_coefs('0, COEF_W'($urandom), COEF_W'($urandom));
					write_coef(REG_UNUSED, COEF_W'($urandom));
				end
			endcase
			if (p == 3) begin
				// sender holds off until the block has fully drained
				queue_random(PHASE_ITEMS / 2);
				wait_idle();
				queue_random(PHASE_ITEMS / 2);
			end else begin
				queue_random(PHASE_ITEMS);
			end
			wait_idle();
		end

		steady = 1'b0;
		repeat (TAIL_CYCLES) @(negedge clk);
		if (reading_expected_q.size() != 0)
			report_mismatch("results left over", longint'(0),
				longint'(reading_expected_q.size()));
		if (fail_count == 0) begin
			$display("** ph_sensor_trimmed_average: PASSED **");
		end else begin
			$display("** ph_sensor_trimmed_average: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/ptav_pkg.sv
design/ptav_seq.sv
design/ptav_dp.sv
design/ph_sensor_trimmed_average.sv
bench/tb_ph_sensor_trimmed_average.sv
